FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ZVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ZVD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/zvd_pkg.sv
// Types and constants of the zero-velocity detector.
`default_nettype none

package zvd_pkg;

    localparam int AXIS_W  = 16;
    localparam int LIM_W   = 15;
    localparam int TIME_W  = 24;
    localparam int STEP_W  = 16;
    localparam int NORM_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY    = 3'd0,
        REG_ACCEL_TOL  = 3'd1,
        REG_GYRO_LIMIT = 3'd2,
        REG_SPEED_LIM  = 3'd3,
        REG_HOLD_TIME  = 3'd4
    } t_cfg_idx;

    localparam int GRAVITY_RST   = 10042;
    localparam int ACCEL_TOL_RST = 256;
    localparam int GYRO_LIM_RST  = 410;
    localparam int SPEED_LIM_RST = 256;
    localparam int HOLD_TIME_RST = 500000;

    localparam logic [NORM_W-1:0] ACC_HI_SQ_RST =
        NORM_W'((GRAVITY_RST + ACCEL_TOL_RST) * (GRAVITY_RST + ACCEL_TOL_RST));
    localparam logic [NORM_W-1:0] ACC_LO_SQ_RST =
        NORM_W'((GRAVITY_RST - ACCEL_TOL_RST) * (GRAVITY_RST - ACCEL_TOL_RST));
    localparam logic [NORM_W-1:0] GYRO_SQ_RST  = NORM_W'(GYRO_LIM_RST * GYRO_LIM_RST);
    localparam logic [NORM_W-1:0] SPEED_SQ_RST = NORM_W'(SPEED_LIM_RST * SPEED_LIM_RST);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // squared thresholds handed from the register file to the datapath
    typedef struct packed {
        logic [NORM_W-1:0] acc_hi_sq;
        logic [NORM_W-1:0] acc_lo_sq;
        logic              acc_lo_en;
        logic [NORM_W-1:0] gyro_sq;
        logic [NORM_W-1:0] speed_sq;
        logic [TIME_W-1:0] hold_time;
    } t_bounds;

endpackage

`default_nettype wire

FILE: rtl/zero_velocity_detector.sv
// Top level of the zero-velocity detector: input register, still test, result register.
//
//   channel  dir  handshake                 word
//   in       in   i_in_valid / o_in_stall   9 axis samples, step_us, hold_mode, on_ground
//   out      out  o_out_valid / i_out_stall stationary
//   cfg      in   i_cfg_valid / o_cfg_ready register index, write data
//
// One word per cycle sustained while the result is not stalled; a word passes the input
// register, then the result register; the still test and saturating time add sit between.
// Reset (synchronous) restores register defaults and clears still time and both valids.
// A stalled result holds the pipe; the input register still fills while it is empty.
// Config writes are always taken; thresholds are registered from the written config registers.
`default_nettype none

module zero_velocity_detector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_accel_x,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_accel_y,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_accel_z,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_rate_x,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_rate_y,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_rate_z,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_vel_x,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_vel_y,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_vel_z,
    input  wire logic        [zvd_pkg::STEP_W-1:0] i_step_us,
    input  wire logic                              i_hold_mode,
    input  wire logic                              i_on_ground,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_stationary,

    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [zvd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [zvd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    zvd_pkg::t_bounds bounds;

    // input register
    logic                              r_s1_valid;
    logic signed [zvd_pkg::AXIS_W-1:0] r_accel_x, r_accel_y, r_accel_z;
    logic signed [zvd_pkg::AXIS_W-1:0] r_rate_x, r_rate_y, r_rate_z;
    logic signed [zvd_pkg::AXIS_W-1:0] r_vel_x, r_vel_y, r_vel_z;
    logic        [zvd_pkg::STEP_W-1:0] r_step_us;
    logic                              r_allowed;

    // state and result register
    logic [zvd_pkg::TIME_W-1:0]        r_still_time;
    logic [zvd_pkg::TIME_W-1:0]        n_still_time;
    logic                              r_out_valid;
    logic                              r_stationary;

    logic                              out_free;
    logic                              s1_fire;
    logic                              in_take;
    logic [zvd_pkg::NORM_W-1:0]        accel_sq;
    logic [zvd_pkg::NORM_W-1:0]        rate_sq;
    logic [zvd_pkg::NORM_W-1:0]        vel_sq;
    logic                              accel_ok;
    logic                              still;
    logic [zvd_pkg::TIME_W:0]          time_sum;

    zvd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bounds    (bounds)
    );

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_accel_x <= i_accel_x;
            r_accel_y <= i_accel_y;
            r_accel_z <= i_accel_z;
            r_rate_x  <= i_rate_x;
            r_rate_y  <= i_rate_y;
            r_rate_z  <= i_rate_z;
            r_vel_x   <= i_vel_x;
            r_vel_y   <= i_vel_y;
            r_vel_z   <= i_vel_z;
            r_step_us <= i_step_us;
            r_allowed <= i_hold_mode || i_on_ground;
        end
    end

    zvd_norm u_norm_accel (
        .i_x       (r_accel_x),
        .i_y       (r_accel_y),
        .i_z       (r_accel_z),
        .o_norm_sq (accel_sq)
    );

    zvd_norm u_norm_rate (
        .i_x       (r_rate_x),
        .i_y       (r_rate_y),
        .i_z       (r_rate_z),
        .o_norm_sq (rate_sq)
    );

    zvd_norm u_norm_vel (
        .i_x       (r_vel_x),
        .i_y       (r_vel_y),
        .i_z       (r_vel_z),
        .o_norm_sq (vel_sq)
    );

    assign accel_ok = (accel_sq < bounds.acc_hi_sq)
                   && (!bounds.acc_lo_en || (accel_sq > bounds.acc_lo_sq));
    assign still    = r_allowed && accel_ok
                   && (rate_sq < bounds.gyro_sq) && (vel_sq < bounds.speed_sq);

    assign time_sum = {1'b0, r_still_time} + (zvd_pkg::TIME_W+1)'(r_step_us);

    always_comb begin
        if (!still) begin
            n_still_time = '0;
        end else if (time_sum[zvd_pkg::TIME_W]) begin
            n_still_time = zvd_pkg::TIME_MAX;
        end else begin
            n_still_time = time_sum[zvd_pkg::TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still_time <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_still_time <= n_still_time;
                r_out_valid  <= 1'b1;
            end else if (out_free) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_stationary <= (n_still_time > bounds.hold_time);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_stationary = r_stationary;

`include "assert_macros.svh"

    `ZVD_ASSERT_ALWAYS(a_stall_needs_word, !r_s1_valid |-> !o_in_stall, "input stalled with empty input register")
    `ZVD_ASSERT(a_clear_on_motion, (s1_fire && !still) |=> (r_still_time == '0), "still time not cleared on motion")
    `ZVD_ASSERT(a_time_grows, (s1_fire && still) |=> (r_still_time >= $past(r_still_time)), "still time fell on a still word")

endmodule

`default_nettype wire

FILE: rtl/zvd_norm.sv
// Squared Euclidean norm of one signed 3-axis vector.
`default_nettype none

module zvd_norm (
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_x,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_y,
    input  wire logic signed [zvd_pkg::AXIS_W-1:0] i_z,
    output logic             [zvd_pkg::NORM_W-1:0] o_norm_sq
);

    logic signed [2*zvd_pkg::AXIS_W-1:0] sq_x;
    logic signed [2*zvd_pkg::AXIS_W-1:0] sq_y;
    logic signed [2*zvd_pkg::AXIS_W-1:0] sq_z;

    assign sq_x = (2*zvd_pkg::AXIS_W)'(i_x) * (2*zvd_pkg::AXIS_W)'(i_x);
    assign sq_y = (2*zvd_pkg::AXIS_W)'(i_y) * (2*zvd_pkg::AXIS_W)'(i_y);
    assign sq_z = (2*zvd_pkg::AXIS_W)'(i_z) * (2*zvd_pkg::AXIS_W)'(i_z);

    // each square is at most 2^30, so the sum of three stays below 2^32
    assign o_norm_sq = zvd_pkg::NORM_W'(sq_x[2*zvd_pkg::AXIS_W-2:0])
                     + zvd_pkg::NORM_W'(sq_y[2*zvd_pkg::AXIS_W-2:0])
                     + zvd_pkg::NORM_W'(sq_z[2*zvd_pkg::AXIS_W-2:0]);

endmodule

`default_nettype wire

FILE: rtl/zvd_cfg.sv
// Configuration registers and the squared thresholds derived from them.
`default_nettype none

module zvd_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [zvd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [zvd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output zvd_pkg::t_bounds                      o_bounds
);

    logic [zvd_pkg::LIM_W-1:0]  r_gravity;
    logic [zvd_pkg::LIM_W-1:0]  r_accel_tol;
    logic [zvd_pkg::LIM_W-1:0]  r_gyro_limit;
    logic [zvd_pkg::LIM_W-1:0]  r_speed_limit;
    logic [zvd_pkg::TIME_W-1:0] r_hold_time;

    zvd_pkg::t_bounds           r_bounds;
    zvd_pkg::t_bounds           n_bounds;

    logic [zvd_pkg::LIM_W:0]    acc_hi;
    logic [zvd_pkg::LIM_W-1:0]  acc_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity     <= zvd_pkg::LIM_W'(zvd_pkg::GRAVITY_RST);
            r_accel_tol   <= zvd_pkg::LIM_W'(zvd_pkg::ACCEL_TOL_RST);
            r_gyro_limit  <= zvd_pkg::LIM_W'(zvd_pkg::GYRO_LIM_RST);
            r_speed_limit <= zvd_pkg::LIM_W'(zvd_pkg::SPEED_LIM_RST);
            r_hold_time   <= zvd_pkg::TIME_W'(zvd_pkg::HOLD_TIME_RST);
        end else if (i_cfg_valid) begin
            case (zvd_pkg::t_cfg_idx'(i_cfg_index))
                zvd_pkg::REG_GRAVITY:    r_gravity     <= i_cfg_data[zvd_pkg::LIM_W-1:0];
                zvd_pkg::REG_ACCEL_TOL:  r_accel_tol   <= i_cfg_data[zvd_pkg::LIM_W-1:0];
                zvd_pkg::REG_GYRO_LIMIT: r_gyro_limit  <= i_cfg_data[zvd_pkg::LIM_W-1:0];
                zvd_pkg::REG_SPEED_LIM:  r_speed_limit <= i_cfg_data[zvd_pkg::LIM_W-1:0];
                zvd_pkg::REG_HOLD_TIME:  r_hold_time   <= i_cfg_data[zvd_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign acc_hi = {1'b0, r_gravity} + {1'b0, r_accel_tol};
    assign acc_lo = r_gravity - r_accel_tol;

    always_comb begin
        n_bounds.acc_hi_sq = zvd_pkg::NORM_W'(acc_hi) * zvd_pkg::NORM_W'(acc_hi);
        n_bounds.acc_lo_sq = zvd_pkg::NORM_W'(acc_lo) * zvd_pkg::NORM_W'(acc_lo);
        // lower bound only applies when it does not go negative
        n_bounds.acc_lo_en = (r_gravity >= r_accel_tol);
        n_bounds.gyro_sq   = zvd_pkg::NORM_W'(r_gyro_limit) * zvd_pkg::NORM_W'(r_gyro_limit);
        n_bounds.speed_sq  = zvd_pkg::NORM_W'(r_speed_limit) * zvd_pkg::NORM_W'(r_speed_limit);
        n_bounds.hold_time = r_hold_time;
    end

    // thresholds are registered from the written config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.acc_hi_sq <= zvd_pkg::ACC_HI_SQ_RST;
            r_bounds.acc_lo_sq <= zvd_pkg::ACC_LO_SQ_RST;
            r_bounds.acc_lo_en <= 1'b1;
            r_bounds.gyro_sq   <= zvd_pkg::GYRO_SQ_RST;
            r_bounds.speed_sq  <= zvd_pkg::SPEED_SQ_RST;
            r_bounds.hold_time <= zvd_pkg::TIME_W'(zvd_pkg::HOLD_TIME_RST);
        end else begin
            r_bounds <= n_bounds;
        end
    end

    assign o_bounds = r_bounds;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench of the zero-velocity detector, with its scoreboard class.
`default_nettype none

module tb_top;
    import zvd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SAT_RUN     = 280;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = REG_HOLD_TIME + 1;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = {CFG_IDX_W{1'b1}};

    typedef struct {
        logic signed [AXIS_W-1:0] acc[3];
        logic signed [AXIS_W-1:0] rate[3];
        logic signed [AXIS_W-1:0] vel[3];
        logic [STEP_W-1:0]        step;
        logic                     hold;
        logic                     gnd;
    } sample_t;

    typedef struct {
        int unsigned g;
        int unsigned tol;
        int unsigned gyro;
        int unsigned speed;
        int unsigned hold;
    } setting_t;

    // Tracks still time and thresholds, keeps the expected stationary flags in order.
    class stillness_tracker;
        logic [LIM_W-1:0]  gravity;
        logic [LIM_W-1:0]  accel_tol;
        logic [LIM_W-1:0]  gyro_lim;
        logic [LIM_W-1:0]  speed_lim;
        logic [TIME_W-1:0] hold_time;
        logic [TIME_W-1:0] still_time;
        bit                pending_stationary[$];
        int                mismatches;
        int                results_seen;
        int                stationary_seen;

        function new();
            gravity         = LIM_W'(GRAVITY_RST);
            accel_tol       = LIM_W'(ACCEL_TOL_RST);
            gyro_lim        = LIM_W'(GYRO_LIM_RST);
            speed_lim       = LIM_W'(SPEED_LIM_RST);
            hold_time       = TIME_W'(HOLD_TIME_RST);
            still_time      = '0;
            mismatches      = 0;
            results_seen    = 0;
            stationary_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRAVITY:    gravity   = data[LIM_W-1:0];
                REG_ACCEL_TOL:  accel_tol = data[LIM_W-1:0];
                REG_GYRO_LIMIT: gyro_lim  = data[LIM_W-1:0];
                REG_SPEED_LIM:  speed_lim = data[LIM_W-1:0];
                REG_HOLD_TIME:  hold_time = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned norm_sq(logic signed [AXIS_W-1:0] v[3]);
            longint s;
            longint c;
            s = 0;
            for (int k = 0; k < 3; k++) begin
                c = v[k];
                s += c * c;
            end
            return longint'(s);
        endfunction

        function void record_sample(sample_t s);
            longint unsigned a2, w2, v2, hi, lo, gl, sl;
            bit              acc_ok, still;
            logic [TIME_W:0] sum;
            a2 = norm_sq(s.acc);
            w2 = norm_sq(s.rate);
            v2 = norm_sq(s.vel);
            hi = gravity;
            hi += accel_tol;
            acc_ok = a2 < hi * hi;
            // lower bound only exists while tolerance does not swallow gravity
            if (gravity >= accel_tol) begin
                lo = gravity - accel_tol;
                acc_ok = acc_ok && (a2 > lo * lo);
            end
            gl = gyro_lim;
            sl = speed_lim;
            still = acc_ok && (w2 < gl * gl) && (v2 < sl * sl) && (s.hold || s.gnd);
            if (still) begin
                sum = {1'b0, still_time} + s.step;
                still_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
                still_time = '0;
            end
            pending_stationary.push_back(still_time > hold_time);
        endfunction

        function void check_stationary(logic actual);
            bit exp_flag;
            results_seen++;
            if (actual) stationary_seen++;
            if (pending_stationary.size() == 0) begin
                $error("stationary: no result expected, actual %0d", actual);
                mismatches++;
            end else begin
                exp_flag = pending_stationary.pop_front();
                if (actual !== exp_flag) begin
                    $error("stationary mismatch: expected %0d, actual %0d", exp_flag, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [AXIS_W-1:0] i_accel_x = '0;
    logic signed [AXIS_W-1:0] i_accel_y = '0;
    logic signed [AXIS_W-1:0] i_accel_z = '0;
    logic signed [AXIS_W-1:0] i_rate_x = '0;
    logic signed [AXIS_W-1:0] i_rate_y = '0;
    logic signed [AXIS_W-1:0] i_rate_z = '0;
    logic signed [AXIS_W-1:0] i_vel_x = '0;
    logic signed [AXIS_W-1:0] i_vel_y = '0;
    logic signed [AXIS_W-1:0] i_vel_z = '0;
    logic [STEP_W-1:0]        i_step_us = '0;
    logic                     i_hold_mode = 1'b0;
    logic                     i_on_ground = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_stationary;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    zero_velocity_detector dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_rate_x     (i_rate_x),
        .i_rate_y     (i_rate_y),
        .i_rate_z     (i_rate_z),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_vel_z      (i_vel_z),
        .i_step_us    (i_step_us),
        .i_hold_mode  (i_hold_mode),
        .i_on_ground  (i_on_ground),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_stationary (o_stationary),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    stillness_tracker tracker = new();
    bit quiet = 1'b0;
    int cycles = 0;
    int samples_sent = 0;
    int settings_run = 1;
    int stall_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_stationary(o_stationary);
    end

    // receiver back-pressure in short bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_out_stall = 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_stall = 1'b0;
        end
    end

    function automatic logic signed [AXIS_W-1:0] clamp16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return AXIS_W'(v);
    endfunction

    function automatic sample_t mk(int ax, int ay, int az, int rx, int ry, int rz,
                                   int vx, int vy, int vz, int step, bit hold, bit gnd);
        sample_t s;
        s.acc[0]  = clamp16(ax);
        s.acc[1]  = clamp16(ay);
        s.acc[2]  = clamp16(az);
        s.rate[0] = clamp16(rx);
        s.rate[1] = clamp16(ry);
        s.rate[2] = clamp16(rz);
        s.vel[0]  = clamp16(vx);
        s.vel[1]  = clamp16(vy);
        s.vel[2]  = clamp16(vz);
        s.step    = STEP_W'(step);
        s.hold    = hold;
        s.gnd     = gnd;
        return s;
    endfunction

    // one axis near a limit now and then, otherwise all axes well inside it
    function automatic void small_vector(output logic signed [AXIS_W-1:0] v[3], input int lim);
        int r;
        r = lim / 2;
        for (int k = 0; k < 3; k++)
            v[k] = clamp16(int'($urandom_range(0, 2 * r)) - r);
        if ($urandom_range(0, 7) == 0) begin
            v = '{default: '0};
            v[$urandom_range(0, 2)] = clamp16(lim - 1 + int'($urandom_range(0, 2)));
        end
    endfunction

    function automatic sample_t gen_sample();
        sample_t s;
        int      kind, m, g, t, ax;
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            for (int k = 0; k < 3; k++) begin
                s.acc[k]  = AXIS_W'($urandom);
                s.rate[k] = AXIS_W'($urandom);
                s.vel[k]  = AXIS_W'($urandom);
            end
            s.step = STEP_W'($urandom);
            s.hold = 1'($urandom);
            s.gnd  = 1'($urandom);
            return s;
        end
        g = tracker.gravity;
        t = tracker.accel_tol;
        m = g + int'($urandom_range(0, 2 * t + 4)) - t - 2;
        if (m < 0) m = 0;
        for (int k = 0; k < 3; k++)
            s.acc[k] = clamp16(int'($urandom_range(0, 128)) - 64);
        ax = $urandom_range(0, 2);
        s.acc[ax] = $urandom_range(0, 1) ? clamp16(m) : clamp16(-m);
        small_vector(s.rate, tracker.gyro_lim);
        small_vector(s.vel, tracker.speed_lim);
        case ($urandom_range(0, 3))
            0: s.step = '0;
            1: s.step = '1;
            default: s.step = STEP_W'($urandom);
        endcase
        {s.hold, s.gnd} = 2'($urandom_range(1, 3));
        if (kind == 9) begin
            // break exactly one of the still conditions (or at least try to)
            case ($urandom_range(0, 3))
                0: {s.hold, s.gnd} = 2'b00;
                1: s.acc[$urandom_range(0, 2)] = AXIS_W'($urandom);
                2: s.rate[$urandom_range(0, 2)] = AXIS_W'($urandom);
                default: s.vel[$urandom_range(0, 2)] = AXIS_W'($urandom);
            endcase
        end
        return s;
    endfunction

    task automatic send_sample(sample_t s);
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_accel_x   = s.acc[0];
        i_accel_y   = s.acc[1];
        i_accel_z   = s.acc[2];
        i_rate_x    = s.rate[0];
        i_rate_y    = s.rate[1];
        i_rate_z    = s.rate[2];
        i_vel_x     = s.vel[0];
        i_vel_y     = s.vel[1];
        i_vel_z     = s.vel[2];
        i_step_us   = s.step;
        i_hold_mode = s.hold;
        i_on_ground = s.gnd;
        do @(posedge i_clk); while (o_in_stall);
        tracker.record_sample(s);
        samples_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++)
            send_sample(gen_sample());
    endtask

    // stop sending and let every outstanding word come out
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_stationary.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    // 15-bit registers always get junk in the unused upper bits
    task automatic apply_setting(setting_t c);
        cfg_write(REG_GRAVITY,    {9'($urandom), LIM_W'(c.g)});
        cfg_write(REG_ACCEL_TOL,  {9'($urandom), LIM_W'(c.tol)});
        cfg_write(REG_GYRO_LIMIT, {9'($urandom), LIM_W'(c.gyro)});
        cfg_write(REG_SPEED_LIM,  {9'($urandom), LIM_W'(c.speed)});
        cfg_write(REG_HOLD_TIME,  TIME_W'(c.hold));
        for (int k = IDX_UNUSED_LO; k <= IDX_UNUSED_HI; k++)
            cfg_write(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        settings_run++;
    endtask

    task automatic new_setting(setting_t c);
        drain();
        apply_setting(c);
    endtask

    initial begin
        setting_t c;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset thresholds: |a| in (9786, 10298), |w| < 410, |v| < 256, hold 500000
        send_sample(mk(0, 0, 10042, 0, 0, 0, 0, 0, 0, 65535, 1'b0, 1'b1));
        send_sample(mk(0, 0, 10042, 0, 0, 0, 0, 0, 0, 65535, 1'b1, 1'b0));
        send_sample(mk(0, 0, 10042, 0, 0, 0, 0, 0, 0, 65535, 1'b1, 1'b1));
        repeat (5) send_sample(mk(0, 0, -10042, 5, -5, 0, 3, 0, -3, 65535, 1'b1, 1'b1));
        send_sample(mk(0, 0, 10042, 0, 0, 0, 0, 0, 0, 65535, 1'b0, 1'b0));
        send_sample(mk(0, 0, 10298, 0, 0, 0, 0, 0, 0, 100, 1'b1, 1'b1));
        send_sample(mk(0, 0, 10297, 0, 0, 0, 0, 0, 0, 100, 1'b1, 1'b1));
        send_sample(mk(9786, 0, 0, 0, 0, 0, 0, 0, 0, 100, 1'b1, 1'b1));
        send_sample(mk(0, -9787, 0, 0, 0, 0, 0, 0, 0, 100, 1'b1, 1'b1));
        send_sample(mk(0, 0, 10042, 410, 0, 0, 0, 0, 0, 100, 1'b1, 1'b1));
        send_sample(mk(0, 0, 10042, 0, -409, 0, 0, 0, 0, 100, 1'b1, 1'b1));
        send_sample(mk(0, 0, 10042, 0, 0, 0, 0, 0, 256, 100, 1'b1, 1'b1));
        send_sample(mk(0, 0, 10042, 0, 0, 0, -255, 0, 0, 100, 1'b1, 1'b1));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768, -32768, 65535, 1'b1, 1'b1));
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767,
                       32767, 32767, 32767, 0, 1'b1, 1'b1));
        send_sample(mk(0, 0, 10042, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        send_random(100);

        // tolerance equal to gravity: zero accel fails, any nonzero magnitude below 2000 passes
        c = '{g: 1000, tol: 1000, gyro: 32767, speed: 32767, hold: 0};
        new_setting(c);
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 10, 1'b1, 1'b1));
        send_sample(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 10, 1'b1, 1'b1));
        send_random(60);

        // tolerance above gravity with a zero gyro limit
        c = '{g: 100, tol: 32767, gyro: 0, speed: 32767, hold: 1000};
        new_setting(c);
        send_random(60);

        // top gravity, zero tolerance, zero speed limit, top hold time
        c = '{g: 32767, tol: 0, gyro: 32767, speed: 0, hold: 16777215};
        new_setting(c);
        send_random(60);

        // long still run drives still time into saturation
        c = '{g: 16384, tol: 16383, gyro: 32767, speed: 32767, hold: 16777215};
        new_setting(c);
        repeat (SAT_RUN) send_sample(mk(0, 0, 16384, 0, 0, 0, 0, 0, 0, 65535, 1'b1, 1'b1));
        send_random(20);
        drain();
        repeat (SAT_RUN) send_sample(mk(0, 0, 16384, 0, 0, 0, 0, 0, 0, 65535, 1'b0, 1'b1));

        // hold time just below saturation: flag is set right away
        c.hold = 16777214;
        new_setting(c);
        send_sample(mk(0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        send_random(60);

        for (int p = 0; p < 4; p++) begin
            c.g     = $urandom_range(8000, 12000);
            c.tol   = $urandom_range(0, 2000);
            c.gyro  = $urandom_range(1, 32767);
            c.speed = $urandom_range(1, 32767);
            c.hold  = $urandom_range(0, 1 << 20);
            new_setting(c);
            send_random(40);
        end

        // back to defaults, no idling on either side
        c = '{g: GRAVITY_RST, tol: ACCEL_TOL_RST, gyro: GYRO_LIM_RST,
              speed: SPEED_LIM_RST, hold: HOLD_TIME_RST};
        new_setting(c);
        quiet = 1'b1;
        send_random(120);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_stationary.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (tracker.pending_stationary.size() != 0) begin
            $error("stationary: %0d expected results never arrived",
                   tracker.pending_stationary.size());
            tracker.mismatches++;
        end

        $display("Ran %0d samples across %0d threshold settings, incl. saturation and bounds.",
                 samples_sent, settings_run);
        $display("Checked %0d results, %0d of them stationary, %0d mismatches.",
                 tracker.results_seen, tracker.stationary_seen, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
